// ----- sv/hkr_pkg.sv -----
// ----------------------------------------------------------------------------
// hkr_pkg
// Shared constants and types for the HID keyboard report tracker.
// ----------------------------------------------------------------------------
package hkr_pkg;

  localparam int KeySlots    = 6;
  localparam int ReportSlots = 6;
  localparam int SlotIdxW    = (KeySlots > 1) ? $clog2(KeySlots) : 1;
  localparam int ReportW     = 8 * (ReportSlots + 1);

  typedef logic [7:0]          usage_t;
  typedef logic [SlotIdxW-1:0] slot_idx_t;

  localparam usage_t    UsageNone = 8'h00;
  localparam usage_t    ModFirst  = 8'hE0;
  localparam usage_t    ModLast   = 8'hE7;
  localparam slot_idx_t SlotLast  = slot_idx_t'(KeySlots - 1);

  typedef struct packed {
    logic      we;
    slot_idx_t idx;
    usage_t    data;
  } slot_wr_t;

  typedef struct packed {
    logic hit;
    logic empty;
  } slot_cmp_t;

endpackage

// ----- sv/hkr_slot_file.sv -----
// ----------------------------------------------------------------------------
// hkr_slot_file
// Held-key slot registers with one indexed compare unit and one write port.
// ----------------------------------------------------------------------------
module hkr_slot_file import hkr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  slot_idx_t                 rd_idx_i,
  input  usage_t                    key_i,
  input  slot_wr_t                  wr_i,
  output slot_cmp_t                 cmp_o,
  output logic [8*ReportSlots-1:0]  slots_o
);

  usage_t slots_q [KeySlots];
  usage_t rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeySlots; i++) begin
        slots_q[i] <= UsageNone;
      end
    end else if (wr_i.we) begin
      slots_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign rd_data     = slots_q[rd_idx_i];
  assign cmp_o.hit   = (rd_data == key_i);
  assign cmp_o.empty = (rd_data == UsageNone);

  always_comb begin
    slots_o = '0;
    for (int j = 0; j < ReportSlots; j++) begin
      if (j < KeySlots) begin
        slots_o[8*j +: 8] = slots_q[j % KeySlots];
      end
    end
  end

endmodule

// ----- sv/hid_keyboard_report_tracker.sv -----
// ----------------------------------------------------------------------------
// hid_keyboard_report_tracker
// Boot-keyboard state tracker emitting six-key-rollover reports.
// ----------------------------------------------------------------------------
// A key event word with a zero usage returns from decode to idle, a modifier
// goes from decode to emit, and a normal key goes through decode, scan, apply
// and emit, the single slot comparator walking the slots one per cycle. A tick
// word returns from decode to idle, or goes to emit to send an idle report.
// The result register lets a new word enter while a report waits; a second
// report waits in the emit step until the first one is taken.
module hid_keyboard_report_tracker import hkr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               idle_rate_we_i,
  input  logic [7:0]         idle_rate_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // [7:0] key_usage, [8] pressed, [15:9] zero
  input  logic [15:0]        s_axis_tdata_i,
  // [0] mode
  input  logic               s_axis_tuser_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [7:0] modifier_byte, [15:8] slot_0 up to [55:48] slot_5
  output logic [ReportW-1:0] m_axis_tdata_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_APPLY  = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [7:0]         idle_rate_q;
  logic [7:0]         mod_q, mod_d;
  logic [7:0]         ms_q, ms_d;
  logic [7:0]         mark_q, mark_d;
  logic               mode_q;
  usage_t             key_q;
  logic               down_q;
  slot_idx_t          idx_q, idx_d;
  logic               hit_q, hit_d;
  slot_idx_t          hit_idx_q, hit_idx_d;
  logic               free_q, free_d;
  slot_idx_t          free_idx_q, free_idx_d;
  logic               out_valid_q, out_valid_d;
  logic [ReportW-1:0] out_data_q;
  logic               out_load;
  logic               accept;
  logic               is_mod;
  logic [2:0]         mod_bit;
  logic [7:0]         ms_inc;
  logic [7:0]         elapsed;
  logic [7:0]         limit;
  slot_wr_t           slot_wr;
  slot_cmp_t          slot_cmp;
  logic [8*ReportSlots-1:0] slots;

  hkr_slot_file u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (idx_q),
    .key_i    (key_q),
    .wr_i     (slot_wr),
    .cmp_o    (slot_cmp),
    .slots_o  (slots)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_mod          = (key_q >= ModFirst) && (key_q <= ModLast);
  assign mod_bit         = 3'(key_q - ModFirst);
  assign ms_inc          = ms_q + 8'd1;
  assign elapsed         = ms_inc - mark_q;
  assign limit           = {idle_rate_q[5:0], 2'b00};

  always_comb begin
    state_d    = state_q;
    mod_d      = mod_q;
    ms_d       = ms_q;
    mark_d     = mark_q;
    idx_d      = idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    slot_wr    = '0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        idx_d  = '0;
        hit_d  = 1'b0;
        free_d = 1'b0;
        if (mode_q) begin
          ms_d    = ms_inc;
          state_d = ST_IDLE;
          if ((idle_rate_q != 8'd0) && (elapsed >= limit)) begin
            mark_d  = ms_inc;
            state_d = ST_EMIT;
          end
        end else if (key_q == UsageNone) begin
          state_d = ST_IDLE;
        end else if (is_mod) begin
          if (down_q) begin
            mod_d = mod_q | (8'd1 << mod_bit);
          end else begin
            mod_d = mod_q & ~(8'd1 << mod_bit);
          end
          state_d = ST_EMIT;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (slot_cmp.hit && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = idx_q;
        end
        if (slot_cmp.empty && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = idx_q;
        end
        if (idx_q == SlotLast) begin
          state_d = ST_APPLY;
        end else begin
          idx_d = idx_q + slot_idx_t'(1);
        end
      end
      ST_APPLY: begin
        if (down_q) begin
          slot_wr.we   = !hit_q && free_q;
          slot_wr.idx  = free_idx_q;
          slot_wr.data = key_q;
        end else begin
          slot_wr.we   = hit_q;
          slot_wr.idx  = hit_idx_q;
          slot_wr.data = UsageNone;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idle_rate_q <= 8'd0;
      mod_q       <= 8'd0;
      ms_q        <= 8'd0;
      mark_q      <= 8'd0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mod_q       <= mod_d;
      ms_q        <= ms_d;
      mark_q      <= mark_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      if (idle_rate_we_i) begin
        idle_rate_q <= idle_rate_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (accept) begin
      mode_q <= s_axis_tuser_i;
      key_q  <= s_axis_tdata_i[7:0];
      down_q <= s_axis_tdata_i[8];
    end
    if (out_load) begin
      out_data_q <= {slots, mod_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_DECODE))
    else $error("accepted word did not enter decode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_EMIT))
    else $error("report raised outside the emit step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= SlotLast))
    else $error("slot scan index out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |=> (state_q == ST_EMIT))
    else $error("slot update not followed by a report");

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the HID keyboard report tracker.
// Key events and millisecond ticks are streamed in with random gaps. A
// behavioral tracker predicts every report, and each report that leaves the
// block is checked field by field against the oldest prediction. The idle
// rate is changed between phases while the block is quiet. Once, the report
// side stalls long enough that the block has to hold off new words.
// ----------------------------------------------------------------------------
module tb;
  import hkr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ModeKey      = 1'b0;
  localparam logic ModeTick     = 1'b1;
  localparam int   CycleLimit   = 400000;
  localparam int   SettleCycles = 20;
  localparam int   PhaseWords   = 130;
  localparam int   HoldAtReport = 150;
  localparam int   HoldCycles   = 300;

  typedef struct {
    bit     mode;
    usage_t usage;
    bit     pressed;
  } key_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               idle_rate_we_i = 1'b0;
  logic [7:0]         idle_rate_i = 8'h00;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [15:0]        s_axis_tdata_i = 16'h0000;
  logic               s_axis_tuser_i = 1'b0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [ReportW-1:0] m_axis_tdata_o;

  key_word_t          pending_words[$];
  logic [ReportW-1:0] expected_reports[$];

  logic [7:0] model_rate = 8'h00;
  logic [7:0] model_mods = 8'h00;
  usage_t     model_slots[KeySlots];
  logic [7:0] model_ticks = 8'h00;
  logic [7:0] model_mark = 8'h00;

  key_word_t live_word;
  bit        word_live = 1'b0;
  int        gap_left = 0;
  bit        idle_on = 1'b1;
  int        ready_wait = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        reports_seen = 0;
  int        fail_count = 0;
  int        cycle_count = 0;

  hid_keyboard_report_tracker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .idle_rate_we_i (idle_rate_we_i),
    .idle_rate_i    (idle_rate_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    foreach (model_slots[i]) model_slots[i] = UsageNone;
  end

  function automatic logic [ReportW-1:0] snapshot_report();
    logic [ReportW-1:0] rep;
    rep = '0;
    rep[7:0] = model_mods;
    for (int j = 0; j < ReportSlots; j++) begin
      if (j < KeySlots) rep[8*(j+1) +: 8] = model_slots[j];
    end
    return rep;
  endfunction

  function automatic void track_word(key_word_t w);
    logic [7:0] elapsed;
    logic [7:0] threshold;
    bit         held;
    if (w.mode == ModeKey) begin
      if (w.usage == UsageNone) return;
      if (w.usage >= ModFirst && w.usage <= ModLast) begin
        model_mods[w.usage[2:0]] = w.pressed;
      end else if (w.pressed) begin
        held = 1'b0;
        for (int i = 0; i < KeySlots; i++) if (model_slots[i] == w.usage) held = 1'b1;
        for (int i = 0; i < KeySlots && !held; i++) begin
          if (model_slots[i] == UsageNone) begin
            model_slots[i] = w.usage;
            held = 1'b1;
          end
        end
      end else begin
        for (int i = 0; i < KeySlots; i++) begin
          if (model_slots[i] == w.usage) begin
            model_slots[i] = UsageNone;
            break;
          end
        end
      end
      expected_reports.push_back(snapshot_report());
    end else begin
      model_ticks = model_ticks + 8'd1;
      if (model_rate != 8'h00) begin
        elapsed = model_ticks - model_mark;
        threshold = {model_rate[5:0], 2'b00};
        if (elapsed >= threshold) begin
          model_mark = model_ticks;
          expected_reports.push_back(snapshot_report());
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  task automatic push_key(input usage_t u, input bit p);
    key_word_t w;
    w.mode = ModeKey;
    w.usage = u;
    w.pressed = p;
    pending_words.push_back(w);
  endtask

  task automatic push_tick(input usage_t u, input bit p);
    key_word_t w;
    w.mode = ModeTick;
    w.usage = u;
    w.pressed = p;
    pending_words.push_back(w);
  endtask

  task automatic push_random_word();
    int   pick;
    usage_t u;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      push_tick(usage_t'($urandom_range(0, 255)), bit'($urandom_range(0, 1)));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 5) u = UsageNone;
      else if (pick < 25) u = ModFirst + usage_t'($urandom_range(0, 7));
      else if (pick < 85) u = 8'h04 + usage_t'($urandom_range(0, 9));
      else u = usage_t'($urandom_range(0, 255));
      push_key(u, $urandom_range(0, 99) < 55);
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || word_live || expected_reports.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_idle_rate(input logic [7:0] rate);
    @(posedge clk_i);
    idle_rate_we_i <= 1'b1;
    idle_rate_i <= rate;
    @(posedge clk_i);
    idle_rate_we_i <= 1'b0;
    model_rate = rate;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        track_word(live_word);
        word_live = 1'b0;
        gap_left = idle_on ? $urandom_range(0, 7) : 0;
      end
      if (!word_live) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          live_word = pending_words.pop_front();
          word_live = 1'b1;
        end
      end
      s_axis_tvalid_i <= word_live;
      s_axis_tdata_i <= {7'b0, live_word.pressed, live_word.usage};
      s_axis_tuser_i <= live_word.mode;
    end
  end

  always @(posedge clk_i) begin
    logic [ReportW-1:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("report %h with none expected", m_axis_tdata_o));
        end else begin
          want = expected_reports.pop_front();
          for (int j = 0; j <= ReportSlots; j++) begin
            if (m_axis_tdata_o[8*j +: 8] !== want[8*j +: 8]) begin
              report_mismatch($sformatf("%s got %h expected %h",
                                        (j == 0) ? "modifier_byte" : $sformatf("slot_%0d", j - 1),
                                        m_axis_tdata_o[8*j +: 8], want[8*j +: 8]));
            end
          end
        end
        ready_wait = idle_on ? $urandom_range(0, 7) : 0;
        if (reports_seen == HoldAtReport && !hold_done) begin
          hold_left = HoldCycles;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (ready_wait > 0) begin
        ready_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [7:0] rates[10];
    rates = '{8'd255, 8'd128, 8'd2, 8'd0, 8'd1, 8'd192, 8'd65, 8'd3, 8'd63, 8'd0};
    rates[9] = 8'($urandom_range(1, 255));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_key(ModFirst, 1'b1);
    push_key(ModLast, 1'b1);
    push_key(8'h04, 1'b1);
    push_key(8'h04, 1'b1);
    push_key(8'h05, 1'b1);
    push_key(8'h06, 1'b1);
    push_key(8'h01, 1'b1);
    push_key(8'hFF, 1'b1);
    push_key(8'h09, 1'b1);
    push_key(8'h06, 1'b0);
    push_key(8'h0A, 1'b1);
    push_key(8'h33, 1'b0);
    push_key(ModFirst, 1'b0);
    push_key(8'hE3, 1'b0);
    push_key(UsageNone, 1'b1);
    push_key(UsageNone, 1'b0);
    push_tick(8'hFF, 1'b1);
    push_key(8'hFF, 1'b0);
    wait_quiet();

    write_idle_rate(8'd1);
    for (int i = 0; i < 6; i++) push_tick(usage_t'(i * 51), bit'(i));
    wait_quiet();
    write_idle_rate(8'd64);
    repeat (3) push_tick(8'h00, 1'b0);
    wait_quiet();

    for (int p = 0; p < 10; p++) begin
      write_idle_rate(rates[p]);
      idle_on = (p == 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
      repeat (PhaseWords) push_random_word();
      wait_quiet();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
